[hw/rtl/brf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

  // request codes on s_tuser
  localparam logic [1:0] REQ_PUT     = 2'd0;
  localparam logic [1:0] REQ_GET     = 2'd1;
  localparam logic [1:0] REQ_PEEK    = 2'd2;
  localparam logic [1:0] REQ_DISCARD = 2'd3;

  // job kinds passed from front to back
  localparam logic [1:0] K_WRITE  = 2'd0;
  localparam logic [1:0] K_SINGLE = 2'd1;
  localparam logic [1:0] K_RUN    = 2'd2;

  localparam int CTR_W   = 9;
  localparam int PTR_W   = 8;
  localparam int CNT_W   = 7;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [PTR_W-1:0] ptr;
    logic [PTR_W-1:0] amask;
    logic [CNT_W-1:0] moved;
    logic [CTR_W-1:0] fill;
    logic [CTR_W-1:0] free;
  } job_t;

  // largest power of two not above v (v nonzero)
  function automatic logic [CTR_W-1:0] floor_pow2(input logic [CTR_W-1:0] v);
    logic [CTR_W-1:0] p;
    p = '0;
    for (int i = 0; i < CTR_W; i++) begin
      if (v[i]) begin
        p = CTR_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/brf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module brf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire brf_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output brf_pkg::job_t      pop_job,
  output logic               valid
);

  brf_pkg::job_t                slots [brf_pkg::Q_DEPTH];
  logic [brf_pkg::Q_AW-1:0]     wptr;
  logic [brf_pkg::Q_AW-1:0]     rptr;
  logic [brf_pkg::Q_AW:0]       fill;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (fill == (brf_pkg::Q_AW+1)'(brf_pkg::Q_DEPTH));
  assign valid    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_job  = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module brf_front #(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  data_in,
  input  wire logic [6:0]  count,
  input  wire logic        cfg_valid,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        q_full,
  output logic             q_push,
  output brf_pkg::job_t    q_job
);

  localparam int SAT_RESET = (DEPTH < 256) ? DEPTH : 256;
  localparam logic [brf_pkg::CTR_W-1:0] RESET_CAP =
    brf_pkg::floor_pow2(brf_pkg::CTR_W'(SAT_RESET));

  logic [brf_pkg::CTR_W-1:0] cap;
  logic [brf_pkg::CTR_W-1:0] wr;
  logic [brf_pkg::CTR_W-1:0] rd;
  logic [brf_pkg::CTR_W-1:0] wr_next;
  logic [brf_pkg::CTR_W-1:0] rd_next;
  logic [brf_pkg::CTR_W-1:0] mask;
  logic [brf_pkg::PTR_W-1:0] amask;
  logic [brf_pkg::CTR_W-1:0] fill;
  logic [brf_pkg::CTR_W-1:0] fill_after;
  logic [brf_pkg::CTR_W-1:0] n_wide;
  logic [brf_pkg::CNT_W-1:0] n;
  logic [brf_pkg::CTR_W-1:0] sat;

  // clip the request to the store depth
  always_comb begin
    if (int'(cfg_data) > DEPTH) begin
      sat = brf_pkg::CTR_W'(DEPTH);
    end else begin
      sat = cfg_data;
    end
  end

  assign q_push = s_tvalid && !q_full;
  assign mask   = brf_pkg::CTR_W'(({1'b0, cap} << 1) - 10'd1);
  assign amask  = brf_pkg::PTR_W'(cap - 9'd1);
  assign fill   = (wr - rd) & mask;

  always_comb begin
    n_wide = (9'(count) < fill) ? 9'(count) : fill;
    if (n_wide > 9'(MAX_RUN)) begin
      n_wide = 9'(MAX_RUN);
    end
    n = brf_pkg::CNT_W'(n_wide);

    wr_next     = wr;
    rd_next     = rd;
    fill_after  = fill;
    q_job.kind  = brf_pkg::K_SINGLE;
    q_job.data  = data_in;
    q_job.ptr   = brf_pkg::PTR_W'(rd) & amask;
    q_job.amask = amask;
    q_job.moved = n;

    unique case (req_type)
      brf_pkg::REQ_PUT: begin
        q_job.ptr   = brf_pkg::PTR_W'(wr) & amask;
        q_job.moved = '0;
        if (fill < cap) begin
          q_job.kind  = brf_pkg::K_WRITE;
          q_job.moved = 7'd1;
          wr_next     = (wr + 9'd1) & mask;
          fill_after  = fill + 9'd1;
        end
      end
      brf_pkg::REQ_GET: begin
        rd_next    = (rd + 9'(n)) & mask;
        fill_after = fill - 9'(n);
        if (n != '0) begin
          q_job.kind = brf_pkg::K_RUN;
        end
      end
      brf_pkg::REQ_PEEK: begin
        if (n != '0) begin
          q_job.kind = brf_pkg::K_RUN;
        end
      end
      brf_pkg::REQ_DISCARD: begin
        rd_next    = (rd + 9'(n)) & mask;
        fill_after = fill - 9'(n);
      end
      default: begin
      end
    endcase

    q_job.fill = fill_after;
    q_job.free = cap - fill_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= RESET_CAP;
      wr  <= '0;
      rd  <= '0;
    end else if (cfg_valid && (cfg_data != '0)) begin
      // new capacity restarts both counters
      cap <= brf_pkg::floor_pow2(sat);
      wr  <= '0;
      rd  <= '0;
    end else if (q_push) begin
      wr <= wr_next;
      rd <= rd_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module brf_back #(
  parameter int DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire brf_pkg::job_t q_job,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         data_out,
  output logic               has_data,
  output logic [6:0]         moved,
  output logic               last,
  output logic [8:0]         fill_level,
  output logic [8:0]         free_space
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [7:0]                mem [DEPTH];
  logic [7:0]                mem_q;
  logic                      state;
  brf_pkg::job_t             cur;
  logic [brf_pkg::CNT_W-1:0] idx;
  logic                      out_free;
  logic                      we;
  logic                      re;
  logic                      run_last;
  logic                      load_out;
  logic [brf_pkg::PTR_W-1:0] next_ptr;
  logic [brf_pkg::PTR_W-1:0] raddr;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;
  assign we       = q_pop && (q_job.kind == brf_pkg::K_WRITE);
  assign run_last = ((idx + 7'd1) == cur.moved);
  assign next_ptr = (cur.ptr + 8'd1) & cur.amask;
  assign re       = (q_pop && (q_job.kind == brf_pkg::K_RUN)) ||
                    ((state == S_RUN) && out_free && !run_last);
  assign raddr    = (state == S_RUN) ? next_ptr : q_job.ptr;
  assign load_out = (q_pop && (q_job.kind != brf_pkg::K_RUN)) ||
                    ((state == S_RUN) && out_free);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ADDR_W'(q_job.ptr)] <= q_job.data;
    end
    if (re) begin
      mem_q <= mem[ADDR_W'(raddr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      m_tvalid <= load_out || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_job;
            idx <= '0;
            if (q_job.kind == brf_pkg::K_RUN) begin
              state <= S_RUN;
            end else begin
              data_out   <= '0;
              has_data   <= 1'b0;
              moved      <= q_job.moved;
              last       <= 1'b1;
              fill_level <= q_job.fill;
              free_space <= q_job.free;
            end
          end
        end
        S_RUN: begin
          // byte already read from the store sits in mem_q until the output frees
          if (out_free) begin
            data_out   <= mem_q;
            has_data   <= 1'b1;
            moved      <= cur.moved;
            last       <= run_last;
            fill_level <= cur.fill;
            free_space <= cur.free;
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              idx     <= idx + 7'd1;
              cur.ptr <= next_ptr;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/byte_ring_fifo_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Byte FIFO on a ring store of DEPTH bytes. Requests enter on s_* (tuser holds the
// request code: put, get, peek, discard) and are classified by the front end, which
// keeps the read and write counters and queues up to four jobs; the back end owns the
// store and turns each job into results on m_*. A put, a discard or a get/peek that
// moves nothing yields one result; a get or peek of n bytes yields n results, one
// per cycle while m_tready does not hold the output, each byte read first into the
// registered mem_q. The front end takes one request per cycle while the job queue
// has room. Writing cfg_data sets the capacity to the largest power of two not above
// it (at most DEPTH) and empties the FIFO; a zero write is ignored. cfg_ready is
// always high and configuration must only be written while the block is idle.
module byte_ring_fifo_top #(
  parameter int DEPTH   = 256,
  parameter int MAX_RUN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // data_in[7:0], count[14:8], zero[15]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data_out[7:0], moved[14:8], fill_level[23:15],
                                      // free_space[32:24], zero[39:33]
  output logic             m_tuser,   // has_data
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);

  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  brf_pkg::job_t push_job;
  brf_pkg::job_t pop_job;
  logic [7:0]    data_out;
  logic [6:0]    moved;
  logic [8:0]    fill_level;
  logic [8:0]    free_space;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign m_tdata   = {7'd0, free_space, fill_level, moved, data_out};

  brf_front #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .req_type  (s_tuser),
    .data_in   (s_tdata[7:0]),
    .count     (s_tdata[14:8]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  brf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .valid    (q_valid)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .data_out   (data_out),
    .has_data   (m_tuser),
    .moved      (moved),
    .last       (m_tlast),
    .fill_level (fill_level),
    .free_space (free_space)
  );

endmodule
`default_nettype wire

[hw/rtl/brf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module brf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // fill plus free is always the power-of-two capacity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot({1'b0, m_tdata[23:15]} + {1'b0, m_tdata[32:24]}))
    else $error("fill and free do not add up to a capacity");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("result without data is not last");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[14:8] != 7'd0))
    else $error("data result reports zero bytes moved");

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/sv/tb_byte_ring_fifo_top.sv]
`timescale 1ns / 1ps
module tb_byte_ring_fifo_top;

  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] din;
    logic [6:0] cnt;
  } fifo_req_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic [6:0] moved;
    logic       last;
    logic [8:0] fill;
    logic [8:0] free;
  } fifo_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  // shadow of the ring and its counters
  logic [7:0] ring_bytes [256];
  int cap_now = 256;
  int wr_ctr = 0;
  int rd_ctr = 0;

  fifo_req_t req_q[$];
  fifo_res_t result_q[$];

  int  req_pushed = 0;
  int  req_taken = 0;
  int  err_cnt = 0;
  int  idle_cyc = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  quiet_in = 1'b0;
  bit  quiet_out = 1'b0;
  logic s_acc = 1'b0;
  logic m_acc = 1'b0;
  logic cfg_acc = 1'b0;

  byte_ring_fifo_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_gap(input bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic int fill_now();
    return (wr_ctr - rd_ctr) & (2 * cap_now - 1);
  endfunction

  function automatic void push_result(input logic [7:0] data, input logic has,
                                      input int moved, input logic last);
    fifo_res_t r;
    int f;
    f = fill_now();
    r.data  = data;
    r.has   = has;
    r.moved = moved[6:0];
    r.last  = last;
    r.fill  = f[8:0];
    r.free  = 9'(cap_now - f);
    result_q.push_back(r);
  endfunction

  // round down to a power of two and empty the FIFO; a zero write is dropped
  task automatic apply_capacity(input logic [8:0] req);
    int r;
    int p;
    if (req != 0) begin
      r = (req > 256) ? 256 : int'(req);
      p = 1;
      while (p * 2 <= r) p = p * 2;
      cap_now = p;
      wr_ctr = 0;
      rd_ctr = 0;
    end
  endtask

  task automatic predict_request(input logic [1:0] kind, input logic [7:0] din,
                                 input logic [6:0] cnt);
    int cmask;
    int amask;
    int fill;
    int n;
    int start;
    int moved;
    cmask = 2 * cap_now - 1;
    amask = cap_now - 1;
    fill = fill_now();
    if (kind == brf_pkg::REQ_PUT) begin
      moved = 0;
      if (fill < cap_now) begin
        ring_bytes[wr_ctr & amask] = din;
        wr_ctr = (wr_ctr + 1) & cmask;
        moved = 1;
      end
      push_result(8'd0, 1'b0, moved, 1'b1);
    end else begin
      n = (int'(cnt) < fill) ? int'(cnt) : fill;
      if (n > 64) n = 64;
      start = rd_ctr;
      if (kind == brf_pkg::REQ_GET || kind == brf_pkg::REQ_DISCARD) begin
        rd_ctr = (rd_ctr + n) & cmask;
      end
      if (kind == brf_pkg::REQ_DISCARD) begin
        push_result(8'd0, 1'b0, n, 1'b1);
      end else if (n == 0) begin
        push_result(8'd0, 1'b0, 0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          push_result(ring_bytes[(start + i) & amask], 1'b1, n, (i == n - 1));
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic check_result();
    fifo_res_t r;
    if (result_q.size() == 0) begin
      $error("result transaction with nothing expected");
      err_cnt++;
    end else begin
      r = result_q.pop_front();
      check_field("data_out", r.data, m_tdata[7:0]);
      check_field("has_data", r.has, m_tuser);
      check_field("moved", r.moved, m_tdata[14:8]);
      check_field("last", r.last, m_tlast);
      check_field("fill_level", r.fill, m_tdata[23:15]);
      check_field("free_space", r.free, m_tdata[32:24]);
    end
  endtask

  // sample handshakes, predict and check
  always @(posedge clk) begin
    if (rst) begin
      s_acc <= 1'b0;
      m_acc <= 1'b0;
      cfg_acc <= 1'b0;
      idle_cyc = 0;
    end else begin
      s_acc <= s_tvalid && s_tready;
      m_acc <= m_tvalid && m_tready;
      cfg_acc <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_capacity(cfg_data);
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata[7:0], s_tdata[14:8]);
        req_taken++;
      end
      if (m_tvalid && m_tready) check_result();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // request driver: hold until the transaction completes, then idle a drawn gap
  always @(negedge clk) begin
    fifo_req_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_acc) begin
      if (s_acc) gap_left = draw_gap(quiet_in);
      if (gap_left > 0 || req_q.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, cur.cnt, cur.din};
        s_tuser <= cur.kind;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_acc) stall_left = draw_gap(quiet_out);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [7:0] din,
                           input logic [6:0] cnt);
    fifo_req_t it;
    it.kind = kind;
    it.din  = din;
    it.cnt  = cnt;
    req_q.push_back(it);
    req_pushed++;
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    @(negedge clk);
    while (req_taken != req_pushed || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // call at a falling edge with the block idle
  task automatic write_capacity(input logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(input int n_items);
    int put_pct;
    int sel;
    logic [1:0] kind;
    logic [6:0] cnt;
    put_pct = $urandom_range(35, 75);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < put_pct) begin
        kind = brf_pkg::REQ_PUT;
      end else begin
        case ($urandom_range(0, 2))
          0: kind = brf_pkg::REQ_GET;
          1: kind = brf_pkg::REQ_PEEK;
          default: kind = brf_pkg::REQ_DISCARD;
        endcase
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) cnt = 7'($urandom_range(0, 16));
      else if (sel < 9) cnt = 7'($urandom_range(0, 64));
      else cnt = 7'($urandom_range(0, 127));
      push_item(kind, 8'($urandom_range(0, 255)), cnt);
    end
  endtask

  initial begin
    int caps [10];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: clipping, empty reads, zero counts
    push_item(brf_pkg::REQ_PUT, 8'h00, 7'd0);
    push_item(brf_pkg::REQ_PUT, 8'hFF, 7'd127);
    push_item(brf_pkg::REQ_PUT, 8'hA5, 7'd0);
    push_item(brf_pkg::REQ_PEEK, 8'h00, 7'd0);
    push_item(brf_pkg::REQ_PEEK, 8'hFF, 7'd127);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd1);
    push_item(brf_pkg::REQ_DISCARD, 8'h00, 7'd1);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd64);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd5);
    push_item(brf_pkg::REQ_PEEK, 8'h00, 7'd1);
    push_item(brf_pkg::REQ_DISCARD, 8'h00, 7'd3);
    push_item(brf_pkg::REQ_PUT, 8'h3C, 7'd0);
    settle();
    // zero write is dropped: the byte must survive
    write_capacity(9'd0);
    push_item(brf_pkg::REQ_PEEK, 8'h00, 7'd1);
    settle();
    // tiny FIFO: put on full drops the byte
    write_capacity(9'd2);
    push_item(brf_pkg::REQ_PUT, 8'h11, 7'd0);
    push_item(brf_pkg::REQ_PUT, 8'h22, 7'd0);
    push_item(brf_pkg::REQ_PUT, 8'h33, 7'd0);
    push_item(brf_pkg::REQ_DISCARD, 8'h00, 7'd64);
    push_item(brf_pkg::REQ_PUT, 8'h44, 7'd0);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd127);
    settle();
    // above DEPTH saturates
    write_capacity(9'd511);
    push_item(brf_pkg::REQ_PUT, 8'h55, 7'd0);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd2);
    settle();
    write_capacity(9'd1);
    push_item(brf_pkg::REQ_PUT, 8'h66, 7'd0);
    push_item(brf_pkg::REQ_PUT, 8'h77, 7'd0);
    push_item(brf_pkg::REQ_GET, 8'h00, 7'd1);
    settle();

    caps = '{4, 256, 1, 511, 16, 0, $urandom_range(1, 511), 2, 64,
             $urandom_range(257, 511)};
    foreach (caps[i]) begin
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      write_capacity(9'(caps[i]));
      run_random(40);
      settle();
    end

    repeat (8) @(negedge clk);
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[byte_ring_fifo_top.f]
hw/rtl/brf_pkg.sv
hw/rtl/brf_queue.sv
hw/rtl/brf_front.sv
hw/rtl/brf_back.sv
hw/rtl/byte_ring_fifo_top.sv
hw/rtl/brf_checker.sv
tb/sv/tb_byte_ring_fifo_top.sv
